@@ hdl/ppp_pkg.sv @@
// Shared constants and helpers for the perspective point projection unit.
package ppp_pkg;

    localparam int COEF_W  = 32;
    localparam int NUM_COEF = 16;
    localparam int IDX_W   = 4;
    localparam int SCR_W   = 14;
    localparam int NDC_W   = 42;
    localparam int SCL_W   = NDC_W + SCR_W + 1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_POINT = 1'b1;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [SCR_W-1:0] WIDTH_RST  = 14'd1920;
    localparam logic [SCR_W-1:0] HEIGHT_RST = 14'd1080;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

endpackage

@@ hdl/ppp_mul.sv @@
// Bit-serial signed 32x32 multiplier, one multiplier bit per cycle.
module ppp_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic               o_done,
    output logic signed [63:0] o_prod
);

    logic        r_busy;
    logic        r_fix;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic        r_neg;
    logic [31:0] r_mc;
    logic [63:0] r_acc;
    logic signed [63:0] r_prod;
    logic [32:0] n_sum;

    assign n_sum = {1'b0, r_acc[63:32]} + (r_acc[0] ? {1'b0, r_mc} : 33'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            r_fix  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_a[31] ^ i_b[31];
                r_mc   <= ppp_pkg::mag32(i_a);
                r_acc  <= {32'd0, ppp_pkg::mag32(i_b)};
            end else if (r_busy) begin
                r_acc <= {n_sum, r_acc[31:1]};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_fix  <= 1'b1;
                end
            end else if (r_fix) begin
                // apply sign after the magnitude product settles
                r_prod <= r_neg ? -$signed(r_acc) : $signed(r_acc);
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

@@ hdl/ppp_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
module ppp_div #(
    parameter int NUM_W = 48
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [31:0]      i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [31:0]      r_rem;
    logic [31:0]      r_den;
    logic [NUM_W-1:0] r_num;
    logic [32:0]      n_trial;
    logic             n_ge;

    assign n_trial = {r_rem, r_num[NUM_W-1]};
    assign n_ge    = n_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_den  <= i_den;
                r_num  <= i_num;
            end else if (r_busy) begin
                r_rem <= n_ge ? 32'(n_trial - {1'b0, r_den}) : n_trial[31:0];
                r_num <= {r_num[NUM_W-2:0], n_ge};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

@@ hdl/perspective_point_projection_unit.sv @@
// Top level: matrix store, sequencer and screen mapping for point projection.
//
//  channel | handshake                 | payload
//  --------+---------------------------+-----------------------------------------------
//  in      | i_in_valid / o_in_ready   | i_command, i_coef_index, i_coef_value, i_point_*
//  out     | o_out_valid / i_out_ready | o_visible, o_screen_x, o_screen_y
//  cfg     | i_cfg_we (no wait)        | i_cfg_index, i_cfg_data
//
// A load beat writes one coefficient. A point beat runs nine serial 32x32 products
// (each a start step plus a run on the shared bit-serial multiplier), three row
// sums and a visibility check. A visible point adds two serial divides, each
// followed by a scale multiply and an offset add. One point is in flight at a time.
// The finished result sits in the output register, so the next beat is taken
// while it waits; a stalled output only holds the sequencer at its last step.
// Reset is synchronous, active low; coefficients clear to zero, viewport to 1920x1080.
module perspective_point_projection_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_command,
    input  logic [3:0]         i_coef_index,
    input  logic signed [31:0] i_coef_value,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_visible,
    output logic signed [31:0] o_screen_x,
    output logic signed [31:0] o_screen_y,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [13:0]        i_cfg_data
);

    localparam int DIV_W = 32 + FRAC_BITS;
    // 0.1 in fixed point, rounded
    localparam logic signed [31:0] THR = 32'(((1 << FRAC_BITS) + 5) / 10);
    localparam logic signed [31:0] NEG_ONE = ~((32'd1 << FRAC_BITS) - 32'd1);
    localparam logic [63:0] NDC_LIM = 64'd1 << 40;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MSTART = 4'd1;
    localparam logic [3:0] S_MWAIT  = 4'd2;
    localparam logic [3:0] S_ROW    = 4'd3;
    localparam logic [3:0] S_CHECK  = 4'd4;
    localparam logic [3:0] S_DWAIT  = 4'd5;
    localparam logic [3:0] S_MULS   = 4'd6;
    localparam logic [3:0] S_ADD    = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0] r_state;

    // matrix store and viewport
    logic signed [31:0] r_coef [ppp_pkg::NUM_COEF];
    logic [ppp_pkg::SCR_W-1:0] r_width;
    logic [ppp_pkg::SCR_W-1:0] r_height;

    // point and row sequencing
    logic signed [31:0] r_px, r_py, r_pz;
    logic [1:0]  r_row;     // 0: x row, 1: y row, 2: w row (matrix row 3)
    logic [1:0]  r_col;
    logic signed [63:0] r_acc;
    logic signed [31:0] r_cx, r_cy, r_cw;

    // divide and scale
    logic        r_sel_y;
    logic        r_neg;
    logic signed [ppp_pkg::NDC_W-1:0] r_ndc;
    logic signed [ppp_pkg::SCL_W-1:0] r_scl;

    // finished result and output register
    logic               r_res_vis;
    logic signed [31:0] r_res_x, r_res_y;
    logic               r_out_valid;
    logic               r_vis;
    logic signed [31:0] r_sx, r_sy;

    logic [1:0]  n_base;
    logic [3:0]  n_addr;
    logic signed [31:0] n_coef_rd;
    logic signed [31:0] n_coord;
    logic        n_mul_start;
    logic        n_mul_done;
    logic signed [63:0] n_prod;
    logic        n_div_start;
    logic        n_div_done;
    logic [DIV_W-1:0] n_div_num;
    logic [DIV_W-1:0] n_quot;
    logic [40:0] n_ndc_mag;
    logic signed [63:0] n_row_sum;
    logic signed [31:0] n_row_sat;
    logic signed [63:0] n_half;
    logic signed [63:0] n_off;
    logic signed [63:0] n_scr;
    logic        n_in_acc;
    logic        n_out_load;

    assign n_base    = (r_row == 2'd2) ? 2'd3 : r_row;
    assign n_addr    = {n_base, r_col};
    assign n_coef_rd = r_coef[n_addr];

    always_comb begin
        unique case (r_col)
            2'd0:    n_coord = r_px;
            2'd1:    n_coord = r_py;
            default: n_coord = r_pz;
        endcase
    end

    assign n_mul_start = (r_state == S_MSTART);

    ppp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_mul_start),
        .i_a     (n_coef_rd),
        .i_b     (n_coord),
        .o_done  (n_mul_done),
        .o_prod  (n_prod)
    );

    // divide starts for x after the visibility check, for y after x is scaled
    assign n_div_start = ((r_state == S_CHECK) && (r_cw >= THR))
                       || ((r_state == S_ADD) && !r_sel_y);
    assign n_div_num = (r_state == S_CHECK)
                     ? {ppp_pkg::mag32(r_cx), {FRAC_BITS{1'b0}}}
                     : {ppp_pkg::mag32(r_cy), {FRAC_BITS{1'b0}}};

    ppp_div #(.NUM_W(DIV_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_div_start),
        .i_num   (n_div_num),
        .i_den   (r_cw),
        .o_done  (n_div_done),
        .o_quot  (n_quot)
    );

    assign n_ndc_mag = (64'(n_quot) > NDC_LIM) ? 41'(NDC_LIM) : 41'(n_quot);

    assign n_row_sum = r_acc + 64'(n_coef_rd);
    assign n_row_sat = ppp_pkg::sat32(n_row_sum);

    // screen = +/-floor(ndc * size / 2) + size * 2^(F-1)
    assign n_half = 64'(r_scl >>> 1);
    assign n_off  = $signed(64'(r_sel_y ? r_height : r_width) << (FRAC_BITS - 1));
    assign n_scr  = r_sel_y ? (n_off - n_half) : (n_off + n_half);

    assign n_in_acc   = i_in_valid && o_in_ready;
    assign n_out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_width     <= ppp_pkg::WIDTH_RST;
            r_height    <= ppp_pkg::HEIGHT_RST;
            for (int i = 0; i < ppp_pkg::NUM_COEF; i++) begin
                r_coef[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    ppp_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                    ppp_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end

            if (n_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (n_in_acc) begin
                        if (i_command == ppp_pkg::CMD_LOAD) begin
                            r_coef[i_coef_index] <= i_coef_value;
                        end else begin
                            r_px    <= i_point_x;
                            r_py    <= i_point_y;
                            r_pz    <= i_point_z;
                            r_row   <= 2'd0;
                            r_col   <= 2'd0;
                            r_acc   <= '0;
                            r_state <= S_MSTART;
                        end
                    end
                end
                S_MSTART: r_state <= S_MWAIT;
                S_MWAIT: begin
                    if (n_mul_done) begin
                        r_acc <= r_acc + (n_prod >>> FRAC_BITS);
                        r_col <= r_col + 2'd1;
                        r_state <= (r_col == 2'd2) ? S_ROW : S_MSTART;
                    end
                end
                S_ROW: begin
                    // r_col is 3 here: translation term
                    unique case (r_row)
                        2'd0:    r_cx <= n_row_sat;
                        2'd1:    r_cy <= n_row_sat;
                        default: r_cw <= n_row_sat;
                    endcase
                    r_acc <= '0;
                    r_col <= 2'd0;
                    r_row <= r_row + 2'd1;
                    r_state <= (r_row == 2'd2) ? S_CHECK : S_MSTART;
                end
                S_CHECK: begin
                    if (r_cw < THR) begin
                        r_res_vis <= 1'b0;
                        r_res_x   <= NEG_ONE;
                        r_res_y   <= NEG_ONE;
                        r_state   <= S_DONE;
                    end else begin
                        r_neg   <= r_cx[31];
                        r_sel_y <= 1'b0;
                        r_state <= S_DWAIT;
                    end
                end
                S_DWAIT: begin
                    if (n_div_done) begin
                        r_ndc <= r_neg ? -$signed({1'b0, n_ndc_mag})
                                       :  $signed({1'b0, n_ndc_mag});
                        r_state <= S_MULS;
                    end
                end
                S_MULS: begin
                    r_scl <= r_ndc * $signed({1'b0, (r_sel_y ? r_height : r_width)});
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (!r_sel_y) begin
                        r_res_x <= ppp_pkg::sat32(n_scr);
                        r_neg   <= r_cy[31];
                        r_sel_y <= 1'b1;
                        r_state <= S_DWAIT;
                    end else begin
                        r_res_y   <= ppp_pkg::sat32(n_scr);
                        r_res_vis <= 1'b1;
                        r_state   <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (n_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_out_load) begin
            r_vis <= r_res_vis;
            r_sx  <= r_res_x;
            r_sy  <= r_res_y;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_visible   = r_vis;
    assign o_screen_x  = r_sx;
    assign o_screen_y  = r_sy;

endmodule

@@ hdl/ppp_checker.sv @@
// Port-level checks for the perspective point projection unit, with bind.
module ppp_checker #(
    parameter int FRAC_BITS = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               i_command,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic               o_visible,
    input logic signed [31:0] o_screen_x,
    input logic signed [31:0] o_screen_y
);

    localparam logic signed [31:0] NEG_ONE = ~((32'd1 << FRAC_BITS) - 32'd1);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_hidden_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_visible |-> o_screen_x == NEG_ONE && o_screen_y == NEG_ONE)
        else $error("hidden point not reported as -1");

    a_point_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_command == ppp_pkg::CMD_POINT |=> !o_in_ready)
        else $error("took a beat while projecting");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind perspective_point_projection_unit ppp_checker #(.FRAC_BITS(FRAC_BITS)) u_ppp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_command   (i_command),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_visible   (o_visible),
    .o_screen_x  (o_screen_x),
    .o_screen_y  (o_screen_y)
);
